### rtl/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // Width of the data ports
  localparam int WORD_W = 64;

  // Request codes
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_REVERSE    = 3'd6
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request beat, clear the read word
    logic exec;     // latch the status code
    logic push;     // write the word and advance the indices
    logic fetch;    // issue the store read at the addressed end
    logic take;     // load the read word, retire a pop
    logic flip;     // toggle the orientation flag
  } dq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_push;
    logic is_read;
    logic is_flip;
    logic full;
    logic empty;
  } dq_stat_t;

endpackage

`default_nettype wire

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of data words held in a ring store.
// Request channel: drive req_type and push_value with start high; the beat
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the result has been shown.
// Result channel: done is high for exactly one cycle and carries read_value,
// status, is_empty and occupancy for that request. The receiver cannot stall
// it, so the result must be sampled in that cycle.
// Sequence: done is shown in RESP, which follows EXEC directly for pushes,
// reverse, the unused code and failed requests; pops and peeks that find a
// word pass through READ between them, for the registered read of the store.
// The next request can be taken in the cycle after done.
// Reverse only toggles an orientation flag; no words move.
// Reset (rst, synchronous) empties the deque, restores normal orientation and
// returns the controller to idle; the store itself is not cleared.

module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    req_type,
  input  wire logic [dq_pkg::WORD_W-1:0]     push_value,
  output logic                               done,
  output logic [dq_pkg::WORD_W-1:0]          read_value,
  output logic [1:0]                         status,
  output logic                               is_empty,
  output logic [$clog2(DEPTH+1)-1:0]         occupancy
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .push_value (push_value),
    .stat       (stat),
    .read_value (read_value),
    .status     (status),
    .is_empty   (is_empty),
    .occupancy  (occupancy)
  );

endmodule

`default_nettype wire

### rtl/dq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/dq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire dq_pkg::dq_stat_t stat,
  output logic                  busy,
  output logic                  done,
  output dq_pkg::dq_cmd_t       cmd
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the request
  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (start) state_next = dq_pkg::S_EXEC;
      end
      dq_pkg::S_EXEC: begin
        if (stat.is_read && !stat.empty) state_next = dq_pkg::S_READ;
        else                             state_next = dq_pkg::S_RESP;
      end
      dq_pkg::S_READ: state_next = dq_pkg::S_RESP;
      dq_pkg::S_RESP: state_next = dq_pkg::S_IDLE;
      default:        state_next = dq_pkg::S_IDLE;
    endcase
  end

  // Drive commands and handshake outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      dq_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      dq_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        cmd.push  = stat.is_push && !stat.full;
        cmd.fetch = stat.is_read && !stat.empty;
        cmd.flip  = stat.is_flip;
      end
      dq_pkg::S_READ: cmd.take = 1'b1;
      dq_pkg::S_RESP: done = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/dq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dq_pkg::dq_cmd_t              cmd,
  input  wire logic [2:0]                   req_type,
  input  wire logic [dq_pkg::WORD_W-1:0]    push_value,
  output dq_pkg::dq_stat_t                  stat,
  output logic [dq_pkg::WORD_W-1:0]         read_value,
  output logic [1:0]                        status,
  output logic                              is_empty,
  output logic [$clog2(DEPTH+1)-1:0]        occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;
  localparam int WW = dq_pkg::WORD_W;

  // Request beat
  logic [2:0]            req_q;
  logic [DATA_WIDTH-1:0] val_q;

  // Ring control
  logic [IW-1:0] front;
  logic [CW-1:0] count;
  logic          reversed;

  // Result
  logic [DATA_WIDTH-1:0] rd_value;
  logic [1:0]            status_q;

  // Decode
  logic is_push, is_read, is_pop, is_flip, at_head, full, empty;
  logic [SW-1:0] back_sum, tail_sum;
  logic [IW-1:0] front_dec, front_inc, back_idx, tail_idx;
  logic [IW-1:0] waddr, raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // Classify the request
  always_comb begin
    is_push = 1'b0;
    is_read = 1'b0;
    is_pop  = 1'b0;
    is_flip = 1'b0;
    unique case (req_q) inside
      dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: is_push = 1'b1;
      dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
        is_read = 1'b1;
        is_pop  = 1'b1;
      end
      dq_pkg::REQ_PEEK_FRONT, dq_pkg::REQ_PEEK_BACK: is_read = 1'b1;
      dq_pkg::REQ_REVERSE: is_flip = 1'b1;
      default: ;
    endcase
  end

  // Even codes address the logical front; orientation picks the physical end
  assign at_head = (req_q[0] == 1'b0) ^ reversed;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  // Ring index arithmetic
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign back_sum  = {1'b0, front} + SW'(count);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
  assign tail_sum  = back_sum - SW'(1);
  assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);

  assign waddr = at_head ? front_dec : back_idx;
  assign raddr = at_head ? front : tail_idx;

  assign stat = '{is_push: is_push, is_read: is_read, is_flip: is_flip,
                  full: full, empty: empty};

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      val_q <= push_value[DATA_WIDTH-1:0];
    end
  end

  // Update front index, count and orientation
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CW'(1);
        if (at_head) front <= front_dec;
      end else if (cmd.take && is_pop) begin
        count <= count - CW'(1);
        if (at_head) front <= front_inc;
      end
      if (cmd.flip) reversed <= ~reversed;
    end
  end

  // Hold the result word and status
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_value <= '0;
    end else if (cmd.take) begin
      rd_value <= ram_rdata;
    end
    if (cmd.exec) begin
      if (is_push && full)       status_q <= dq_pkg::ST_FULL;
      else if (is_read && empty) status_q <= dq_pkg::ST_EMPTY;
      else                       status_q <= dq_pkg::ST_OK;
    end
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (waddr),
    .wdata (val_q),
    .re    (cmd.fetch),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign read_value = WW'(rd_value);
  assign status     = status_q;
  assign is_empty   = empty;
  assign occupancy  = count;

endmodule

`default_nettype wire

### rtl/dq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic [1:0]                 status,
  input wire logic                       is_empty,
  input wire logic [$clog2(DEPTH+1)-1:0] occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  // Reset leaves the block idle with no result beat
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  // An accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // One result beat per request, shown while busy
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !done)
    else $error("result beat not single or not busy");

  // Empty flag agrees with occupancy
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> is_empty == (occupancy == '0))
    else $error("empty flag disagrees with occupancy");

  // A full refusal reports a full deque
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == dq_pkg::ST_FULL |-> occupancy == CW'(DEPTH))
    else $error("full status with deque not full");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .is_empty  (is_empty),
  .occupancy (occupancy)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int RING_DEPTH = 16;
  localparam int TAIL_ITEMS = 200;
  localparam int RANDOM_ITEMS = 2000;
  // Code 7 is outside the request set: the block answers it without effect
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  // One request beat
  typedef struct {
    logic [2:0]  code;
    logic [63:0] word;
  } deque_request_t;

  // One answer of the block
  typedef struct {
    logic [63:0]     read_value;
    dq_pkg::status_t status;
    logic            is_empty;
    logic [4:0]      occupancy;
  } deque_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  req_type = dq_pkg::REQ_PUSH_FRONT;
  logic [63:0] push_value = '0;
  logic        busy;
  logic        done;
  logic [63:0] read_value;
  logic [1:0]  status;
  logic        is_empty;
  logic [4:0]  occupancy;

  deque_request_t requests_pending[$];
  deque_answer_t  answers_due[$];
  deque_answer_t  oldest_due;
  deque_request_t next_beat;

  // Shadow of the deque contents
  logic [63:0] ring [RING_DEPTH];
  logic [3:0]  head_pos = '0;
  logic [4:0]  held = '0;
  logic        flipped = 1'b0;

  int mismatches = 0;
  int gap_left = 0;
  int beats_taken = 0;
  bit idle_on = 1'b1;

  double_ended_queue #(
    .DEPTH(RING_DEPTH),
    .DATA_WIDTH(64)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .push_value(push_value),
    .done(done),
    .read_value(read_value),
    .status(status),
    .is_empty(is_empty),
    .occupancy(occupancy)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow deque and queue the answer it should give
  function automatic void apply_request(input logic [2:0] code, input logic [63:0] word);
    deque_answer_t ans;
    logic at_head;
    logic [3:0] pos;
    ans.read_value = '0;
    ans.status = dq_pkg::ST_OK;
    at_head = (code[0] == 1'b0) != flipped;
    pos = at_head ? head_pos : head_pos + 4'(held - 5'd1);
    case (code)
      dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
        if (held == RING_DEPTH) begin
          ans.status = dq_pkg::ST_FULL;
        end else if (at_head) begin
          head_pos = head_pos - 4'd1;
          ring[head_pos] = word;
          held = held + 5'd1;
        end else begin
          ring[head_pos + held[3:0]] = word;
          held = held + 5'd1;
        end
      end
      dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK,
      dq_pkg::REQ_PEEK_FRONT, dq_pkg::REQ_PEEK_BACK: begin
        if (held == 0) begin
          ans.status = dq_pkg::ST_EMPTY;
        end else begin
          ans.read_value = ring[pos];
          if (code == dq_pkg::REQ_POP_FRONT || code == dq_pkg::REQ_POP_BACK) begin
            if (at_head) head_pos = head_pos + 4'd1;
            held = held - 5'd1;
          end
        end
      end
      dq_pkg::REQ_REVERSE: begin
        flipped = ~flipped;
      end
      default: begin
      end
    endcase
    ans.is_empty = (held == 0);
    ans.occupancy = held;
    answers_due.push_back(ans);
  endfunction

  function automatic void queue_request(input logic [2:0] code, input logic [63:0] word);
    deque_request_t r;
    r.code = code;
    r.word = word;
    requests_pending.push_back(r);
  endfunction

  // Push share: fill phases drive towards full, drain phases towards empty
  function automatic logic [2:0] pick_code(input int push_pct);
    int s;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
    s = $urandom_range(0, 99);
    if (s < 55) return $urandom_range(0, 1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT;
    if (s < 85) return $urandom_range(0, 1) ? dq_pkg::REQ_PEEK_BACK : dq_pkg::REQ_PEEK_FRONT;
    if (s < 97) return dq_pkg::REQ_REVERSE;
    return REQ_UNUSED;
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Stimulus: directed corners first, then phased random traffic
  initial begin
    int push_pct;
    int chunk;
    int made;
    // empty deque: every read fails, reverse and the unused code still answer
    queue_request(dq_pkg::REQ_PEEK_FRONT, '1);
    queue_request(dq_pkg::REQ_PEEK_BACK, '0);
    queue_request(dq_pkg::REQ_POP_FRONT, '1);
    queue_request(dq_pkg::REQ_POP_BACK, '0);
    queue_request(dq_pkg::REQ_REVERSE, '1);
    queue_request(REQ_UNUSED, '1);
    queue_request(dq_pkg::REQ_REVERSE, '0);
    // single word: front and back are the same word
    queue_request(dq_pkg::REQ_PUSH_BACK, 64'hDEAD_BEEF_0BAD_F00D);
    queue_request(dq_pkg::REQ_PEEK_FRONT, '0);
    queue_request(dq_pkg::REQ_PEEK_BACK, '0);
    queue_request(dq_pkg::REQ_POP_BACK, '0);
    // a few words, both ends, with orientation flips between reads
    queue_request(dq_pkg::REQ_PUSH_FRONT, '0);
    queue_request(dq_pkg::REQ_PUSH_BACK, '1);
    queue_request(dq_pkg::REQ_PUSH_FRONT, 64'h8000_0000_0000_0001);
    queue_request(dq_pkg::REQ_PUSH_BACK, 64'h5555_5555_5555_5555);
    queue_request(dq_pkg::REQ_PEEK_FRONT, '0);
    queue_request(dq_pkg::REQ_PEEK_BACK, '0);
    queue_request(dq_pkg::REQ_REVERSE, '0);
    queue_request(dq_pkg::REQ_PEEK_FRONT, '0);
    queue_request(dq_pkg::REQ_PEEK_BACK, '0);
    queue_request(dq_pkg::REQ_POP_FRONT, '0);
    queue_request(dq_pkg::REQ_POP_BACK, '0);
    queue_request(dq_pkg::REQ_REVERSE, '0);
    queue_request(dq_pkg::REQ_POP_FRONT, '0);
    queue_request(dq_pkg::REQ_POP_BACK, 64'hAAAA_AAAA_AAAA_AAAA);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 10;
        default: push_pct = 40;
      endcase
      chunk = $urandom_range(20, 45);
      repeat (chunk) begin
        queue_request(pick_code(push_pct), pick_word());
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: all beats taken, all answers in, then a short settling wait
    while (requests_pending.size() != 0 || start || answers_due.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Driver: hold a beat until taken, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        apply_request(req_type, push_value);
        beats_taken++;
        if (beats_taken % 64 == 0) idle_on = $urandom_range(0, 1);
        if (idle_on && requests_pending.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 15);
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (requests_pending.size() != 0) begin
        next_beat = requests_pending.pop_front();
        req_type <= next_beat.code;
        push_value <= next_beat.word;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed answer with the oldest one due
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer: read_value %h status %0d occupancy %0d",
                 $realtime, read_value, status, occupancy);
        mismatches++;
      end else begin
        oldest_due = answers_due.pop_front();
        if (read_value !== oldest_due.read_value) begin
          $display("%0t: read_value expected %h actual %h",
                   $realtime, oldest_due.read_value, read_value);
          mismatches++;
        end
        if (status !== oldest_due.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $realtime, oldest_due.status, status);
          mismatches++;
        end
        if (is_empty !== oldest_due.is_empty) begin
          $display("%0t: is_empty expected %0d actual %0d",
                   $realtime, oldest_due.is_empty, is_empty);
          mismatches++;
        end
        if (occupancy !== oldest_due.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $realtime, oldest_due.occupancy, occupancy);
          mismatches++;
        end
      end
    end
  end

  // Give up if the run hangs
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
